### rtl/evm_pkg.sv
// Package for the Euler-angle view matrix core: payload types, constants and helpers.
`timescale 1ns / 1ps
package evm_pkg;

	localparam int unsigned SinA = 102943;
	localparam int unsigned SinB = 42047;
	localparam int unsigned SinC = 4640;
	localparam int unsigned QueueDepth = 2;

	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] roll_angle;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} cam_in_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] col0;
		logic signed [31:0] col1;
		logic signed [31:0] col2;
		logic signed [31:0] col3_translate;
		logic               last_row;
	} row_out_t;

	// Trig values are Q16.16 in [-1, 1]; 19 bits signed hold them.
	typedef struct packed {
		logic signed [18:0] sx;
		logic signed [18:0] cx;
		logic signed [18:0] sy;
		logic signed [18:0] cy;
		logic signed [18:0] sz;
		logic signed [18:0] cz;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} trig_t;

	// Round to nearest, ties upwards, then drop 16 fraction bits.
	function automatic logic signed [47:0] rnd16(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd32768;
		return t[63:16];
	endfunction

	// Folds a binary angle into [-16384, 16384] and returns z = 4*s (Q16).
	function automatic logic signed [18:0] fold_z(input logic [15:0] ang);
		logic signed [17:0] s;
		s = 18'(signed'(ang));
		if (s > 18'sd16384) begin
			s = 18'sd32768 - s;
		end else if (s < -18'sd16384) begin
			s = -18'sd32768 - s;
		end
		return 19'(s) <<< 2;
	endfunction

endpackage

### rtl/evm_front.sv
// Front part: accepts camera items and evaluates the six sines and cosines in stages.
`timescale 1ns / 1ps
`default_nettype none
module evm_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire evm_pkg::cam_in_t in_data,
	output logic                 t_valid,
	input  wire logic            t_stall,
	output evm_pkg::trig_t       t_data
);
	localparam int NA = 6;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [18:0]       z_s1 [NA];
	logic signed [18:0]       z_s2 [NA];
	logic signed [18:0]       z_s3 [NA];
	logic signed [18:0]       z_s4 [NA];
	logic signed [18:0]       z2_s2 [NA];
	logic signed [18:0]       z2_s3 [NA];
	logic signed [19:0]       t_s3 [NA];
	logic signed [18:0]       t_s4 [NA];
	logic [95:0]              p_s1, p_s2, p_s3, p_s4;
	logic                     adv;
	logic [15:0]              angs [NA];

	assign adv = !(t_valid && t_stall);
	assign in_stall = !adv;
	assign t_valid = v_s4;

	always_comb begin
		angs[0] = in_data.pitch_angle;
		angs[1] = 16'(in_data.pitch_angle + 16'sd16384);
		angs[2] = in_data.yaw_angle;
		angs[3] = 16'(in_data.yaw_angle + 16'sd16384);
		angs[4] = in_data.roll_angle;
		angs[5] = 16'(in_data.roll_angle + 16'sd16384);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
			p_s2 <= p_s1;
			p_s3 <= p_s2;
			p_s4 <= p_s3;
			for (int i = 0; i < NA; i++) begin
				z_s1[i]  <= evm_pkg::fold_z(angs[i]);
				z_s2[i]  <= z_s1[i];
				z2_s2[i] <= 19'(evm_pkg::rnd16(64'(z_s1[i]) * 64'(z_s1[i])));
				z_s3[i]  <= z_s2[i];
				z2_s3[i] <= z2_s2[i];
				t_s3[i]  <= 20'(64'(evm_pkg::SinB)
					- evm_pkg::rnd16(64'(evm_pkg::SinC) * 64'(z2_s2[i])));
				z_s4[i]  <= z_s3[i];
				t_s4[i]  <= 19'(64'(evm_pkg::SinA)
					- evm_pkg::rnd16(64'(t_s3[i]) * 64'(z2_s3[i])));
			end
		end
	end

	logic signed [18:0] trig [NA];
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			trig[i] = 19'(evm_pkg::rnd16(64'(t_s4[i]) * 64'(z_s4[i])));
		end
		t_data.sx = trig[0];
		t_data.cx = trig[1];
		t_data.sy = trig[2];
		t_data.cy = trig[3];
		t_data.sz = trig[4];
		t_data.cz = trig[5];
		t_data.px = p_s4[95:64];
		t_data.py = p_s4[63:32];
		t_data.pz = p_s4[31:0];
	end
endmodule
`default_nettype wire

### rtl/evm_queue.sv
// Short queue between the trig front and the row back end.
`timescale 1ns / 1ps
`default_nettype none
module evm_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_valid,
	output logic                wr_stall,
	input  wire evm_pkg::trig_t wr_data,
	output logic                rd_valid,
	input  wire logic           rd_stall,
	output evm_pkg::trig_t      rd_data
);
	evm_pkg::trig_t mem_q [evm_pkg::QueueDepth];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           wr_en, rd_en;

	assign wr_stall = (cnt_q == 2'(evm_pkg::QueueDepth));
	assign rd_valid = (cnt_q != 2'd0);
	assign wr_en = wr_valid && !wr_stall;
	assign rd_en = rd_valid && !rd_stall;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= !wp_q;
			if (rd_en) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

### rtl/evm_back.sv
// Back end: builds one view-matrix row per step in a short pipeline.
`timescale 1ns / 1ps
`default_nettype none
module evm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           t_valid,
	output logic                t_stall,
	input  wire evm_pkg::trig_t t_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output evm_pkg::row_out_t   out_data
);
	logic [1:0]          row_q;
	logic                adv;
	logic                v_s1, v_s2, v_s3, v_s4;
	logic [1:0]          r_s1, r_s2, r_s3;
	logic signed [18:0]  m0_s1, m1_s1, m2_s1, sz_s1, cz_s1;
	logic signed [31:0]  px_s1, py_s1, pz_s1;
	logic signed [19:0]  c0_s2, c1_s2;
	logic signed [18:0]  c2_s2;
	logic signed [31:0]  px_s2, py_s2, pz_s2;
	logic signed [51:0]  a0_s3, a1_s3, a2_s3;
	logic signed [19:0]  c0_s3, c1_s3;
	logic signed [18:0]  c2_s3;
	logic signed [63:0]  acc;
	logic signed [47:0]  tr;
	logic signed [18:0]  m0, m1, m2;
	logic                take;

	assign adv = !(out_valid && out_stall);
	assign take = adv && t_valid;
	// The item leaves the queue with its last row.
	assign t_stall = !(adv && row_q == 2'd2);

	always_comb begin
		case (row_q)
			2'd0: begin
				m0 = t_data.cy; m1 = '0; m2 = t_data.sy;
			end
			2'd1: begin
				m0 = 19'(evm_pkg::rnd16(64'(t_data.sx) * 64'(t_data.sy)));
				m1 = t_data.cx;
				m2 = 19'(-evm_pkg::rnd16(64'(t_data.sx) * 64'(t_data.cy)));
			end
			default: begin
				m0 = 19'(-evm_pkg::rnd16(64'(t_data.cx) * 64'(t_data.sy)));
				m1 = t_data.sx;
				m2 = 19'(evm_pkg::rnd16(64'(t_data.cx) * 64'(t_data.cy)));
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 2'd0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			if (t_valid) row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1 <= row_q;
			m0_s1 <= m0; m1_s1 <= m1; m2_s1 <= m2;
			sz_s1 <= t_data.sz; cz_s1 <= t_data.cz;
			px_s1 <= t_data.px; py_s1 <= t_data.py; pz_s1 <= t_data.pz;
			r_s2 <= r_s1;
			c0_s2 <= 20'(evm_pkg::rnd16(64'(m0_s1) * 64'(cz_s1))
				+ evm_pkg::rnd16(64'(m1_s1) * 64'(sz_s1)));
			c1_s2 <= 20'(evm_pkg::rnd16(64'(m1_s1) * 64'(cz_s1))
				- evm_pkg::rnd16(64'(m0_s1) * 64'(sz_s1)));
			c2_s2 <= m2_s1;
			px_s2 <= px_s1; py_s2 <= py_s1; pz_s2 <= pz_s1;
			r_s3 <= r_s2;
			a0_s3 <= 52'(c0_s2) * 52'(px_s2);
			a1_s3 <= 52'(c1_s2) * 52'(py_s2);
			a2_s3 <= 52'(c2_s2) * 52'(pz_s2);
			c0_s3 <= c0_s2; c1_s3 <= c1_s2; c2_s3 <= c2_s2;
			out_data.row_index <= r_s3;
			out_data.last_row <= (r_s3 == 2'd2);
			out_data.col0 <= 32'(c0_s3);
			out_data.col1 <= 32'(c1_s3);
			out_data.col2 <= 32'(c2_s3);
			if (tr > 48'sh7FFFFFFF) out_data.col3_translate <= 32'sh7FFFFFFF;
			else if (tr < -48'sh80000000) out_data.col3_translate <= 32'sh80000000;
			else out_data.col3_translate <= 32'(tr);
		end
	end

	always_comb begin
		acc = -(64'(a0_s3) + 64'(a1_s3) + 64'(a2_s3));
		tr = evm_pkg::rnd16(acc);
	end

	assign out_valid = v_s4;
endmodule
`default_nettype wire

### rtl/euler_view_matrix_core.sv
// Top level of the Euler-angle view matrix core.
//  channel | direction | payload            | handshake
//  in      | into core | evm_pkg::cam_in_t  | in_valid / in_stall
//  out     | from core | evm_pkg::row_out_t | out_valid / out_stall
// The back end makes one row per cycle when the output flows, three rows per item, and
// so sets the rate at which items are taken. A row passes the front stages, the queue
// and the back stages in turn, and the rows of one item leave in order.
// Reset clears all valid flags and the queue; payload registers are not reset.
// A stall on the output freezes the back end, fills the queue, then stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module euler_view_matrix_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire evm_pkg::cam_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output evm_pkg::row_out_t     out_data
);
	logic           f_valid, f_stall, q_valid, q_stall;
	evm_pkg::trig_t f_data, q_data;

	evm_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.t_valid(f_valid), .t_stall(f_stall), .t_data(f_data)
	);

	evm_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
		.rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_data)
	);

	evm_back u_back (
		.clk, .arst_n,
		.t_valid(q_valid), .t_stall(q_stall), .t_data(q_data),
		.out_valid, .out_stall, .out_data
	);

`ifndef SYNTHESIS
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_row == (out_data.row_index == 2'd2)))
		else $error("last_row flag disagrees with row index");
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.row_index != 2'd2) ##1 out_valid
		|-> out_data.row_index == $past(out_data.row_index) + 2'd1)
		else $error("rows out of order");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.row_index != 2'd3)
		else $error("row index out of range");
`endif
endmodule
`default_nettype wire
